// ===== src/assert_macros.svh =====
// assertion macros used by the rtl file
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/ced_pkg.sv =====
// constants and types for the endpoint discovery engine
// no dependencies
`default_nettype none
package ced_pkg;

   localparam int MAX_ENDPOINTS = 32;
   localparam int IDX_W = $clog2(MAX_ENDPOINTS);
   localparam int CNT_W = 6;

   // phase codes
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_HELLO = 2'd1;
   localparam logic [1:0] PH_MAP   = 2'd2;
   localparam logic [1:0] PH_PWR   = 2'd3;

   // send permission classes
   localparam logic [1:0] PERMIT_MGMT = 2'd0;
   localparam logic [1:0] PERMIT_LOW  = 2'd1;
   localparam logic [1:0] PERMIT_ALL  = 2'd2;

   // register indexes
   localparam logic CSR_DISC_EN   = 1'b0;
   localparam logic CSR_ENTRY_CNT = 1'b1;

   // request kinds
   localparam logic REQ_TABLE_WR = 1'b0;
   localparam logic REQ_MSG      = 1'b1;

   // result kinds
   localparam logic KIND_SEND = 1'b0;
   localparam logic KIND_DROP = 1'b1;

   // message types
   localparam logic [3:0] MT_HELLO  = 4'd1;
   localparam logic [3:0] MT_PWR_OK = 4'd7;
   localparam logic [3:0] MT_MAP    = 4'd8;
   localparam logic [3:0] MT_IGNORE = 4'd11;

   // outgoing message templates
   localparam logic [63:0] HELLO_REPLY = 64'h0020_0001_0000_0000;
   localparam logic [63:0] MAP_ACK     = 64'h0080_0000_0000_0000;
   localparam logic [63:0] START_MSG   = 64'h0050_0000_0000_0002;
   localparam logic [63:0] PWR_ACK     = 64'h00b0_0000_0000_0000;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MARK  = 4'b0010,
      ST_ACK   = 4'b0100,
      ST_START = 4'b1000
   } state_type;

endpackage
`default_nettype wire

// ===== src/coprocessor_endpoint_discovery_fsm.sv =====
// endpoint discovery handshake engine, one module; uses ced_pkg and assert_macros.svh
// hello, power-ok and dropped words: one result word the cycle after start, busy stays low
// map block: table walk of n = min(entry_count, 32) reads, then the ack word
//   (no walk when n is 0); last block: start words for flagged entries follow the ack, one per cycle
// synchronous reset: phase wait hello, flags cleared, outputs quiet; table contents kept
`default_nettype none
`include "assert_macros.svh"
module coprocessor_endpoint_discovery_fsm (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_type,
   input  wire logic [ced_pkg::IDX_W-1:0]     req_entry_index,
   input  wire logic [7:0]                    req_entry_epnum,
   input  wire logic [63:0]                   req_msg_word,
   output logic                               rsp_strobe,
   output logic                               rsp_result_kind,
   output logic [63:0]                        rsp_out_msg,
   output logic [1:0]                         rsp_phase_now,
   output logic [1:0]                         rsp_send_permit,
   output logic                               rsp_last,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [ced_pkg::CNT_W-1:0]     csr_wdata
);

   localparam int N = ced_pkg::MAX_ENDPOINTS;
   localparam int IW = ced_pkg::IDX_W;
   localparam int CW = ced_pkg::CNT_W;

   // endpoint number table, one synchronous port
   logic [7:0]    table_mem [N];
   logic [7:0]    rd_data_ff;
   logic [IW-1:0] rd_addr;
   logic          wr_en;

   // control state
   ced_pkg::state_type state_ff, state_in;
   logic [1:0]    phase_ff, phase_in;
   logic          disc_en_ff, disc_en_in;
   logic [CW-1:0] entry_count_ff, entry_count_in;
   logic [N-1:0]  flags_ff, flags_in;

   // map walk
   logic [IW-1:0] idx_ff, idx_in;
   logic          more_ff, more_in;
   logic          mrdv_ff, mrdv_in;
   logic [IW-1:0] mrd_idx_ff, mrd_idx_in;
   logic [31:0]   seen_ff, seen_in;
   logic [31:0]   bitmap_ff, bitmap_in;
   logic [2:0]    block_ff, block_in;
   logic          lastblk_ff, lastblk_in;

   // start walk
   logic [N-1:0]  pending_ff, pending_in;
   logic          srdv_ff, srdv_in;
   logic          slast_ff, slast_in;

   // registered result word for single-result messages and the ack
   logic          out_v_ff, out_v_in;
   logic          out_kind_ff, out_kind_in;
   logic [63:0]   out_msg_ff, out_msg_in;
   logic          out_last_ff, out_last_in;

   logic          accept;
   logic [3:0]    mtype;
   logic [CW-1:0] cnt_eff;
   logic [N-1:0]  cnt_mask;
   logic [N-1:0]  low_bit;
   logic [IW-1:0] low_idx;
   logic [N-1:0]  pend_next;
   logic [N-1:0]  active_flags;
   logic [7:0]    ep;
   logic          blk_match;

   assign accept = start & ~busy;
   assign busy   = (state_ff != ced_pkg::ST_IDLE);
   assign mtype  = req_msg_word[55:52];

   // count above the table size acts as the table size
   assign cnt_eff = (entry_count_ff > CW'(N)) ? CW'(N) : entry_count_ff;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         cnt_mask[i] = (CW'(i) < cnt_eff);
      end
   end

   assign active_flags = flags_ff & cnt_mask;

   // lowest pending entry of the start walk
   assign low_bit   = pending_ff & (~pending_ff + N'(1));
   assign pend_next = pending_ff & ~low_bit;
   always_comb begin
      low_idx = '0;
      for (int i = 0; i < N; i++) begin
         if (low_bit[i]) begin
            low_idx = low_idx | IW'(i);
         end
      end
   end

   // table word returned for the map walk
   assign ep        = rd_data_ff;
   assign blk_match = (ep[7:5] == block_ff);

   // address: request index on accept, map walk counts down, start walk picks lowest pending
   always_comb begin
      if (state_ff == ced_pkg::ST_START) begin
         rd_addr = low_idx;
      end else if (accept) begin
         rd_addr = req_entry_index;
      end else begin
         rd_addr = idx_ff;
      end
   end

   assign wr_en = accept && (req_type == ced_pkg::REQ_TABLE_WR)
                  && ({1'b0, req_entry_index} < CW'(N));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[req_entry_index] <= req_entry_epnum;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      disc_en_in     = disc_en_ff;
      entry_count_in = entry_count_ff;
      flags_in       = flags_ff;
      idx_in         = idx_ff;
      more_in        = more_ff;
      mrdv_in        = 1'b0;
      mrd_idx_in     = idx_ff;
      seen_in        = seen_ff;
      bitmap_in      = bitmap_ff;
      block_in       = block_ff;
      lastblk_in     = lastblk_ff;
      pending_in     = pending_ff;
      srdv_in        = 1'b0;
      slast_in       = slast_ff;
      out_v_in       = 1'b0;
      out_kind_in    = out_kind_ff;
      out_msg_in     = out_msg_ff;
      out_last_in    = 1'b1;

      unique case (state_ff)
         ced_pkg::ST_IDLE: begin
            if (accept && (req_type == ced_pkg::REQ_MSG)) begin
               out_kind_in = ced_pkg::KIND_SEND;
               if ((phase_ff == ced_pkg::PH_IDLE) && (mtype == ced_pkg::MT_IGNORE)) begin
                  // silently dropped
               end else if (((phase_ff == ced_pkg::PH_IDLE) ||
                             (phase_ff == ced_pkg::PH_HELLO)) &&
                            (mtype == ced_pkg::MT_HELLO)) begin
                  out_v_in   = 1'b1;
                  out_msg_in = ced_pkg::HELLO_REPLY | {32'b0, req_msg_word[31:0]};
                  phase_in   = ced_pkg::PH_MAP;
               end else if ((phase_ff == ced_pkg::PH_MAP) &&
                            (mtype == ced_pkg::MT_MAP)) begin
                  bitmap_in  = req_msg_word[31:0];
                  block_in   = req_msg_word[34:32];
                  lastblk_in = req_msg_word[51];
                  seen_in    = '0;
                  if (req_msg_word[51]) begin
                     phase_in = ced_pkg::PH_PWR;
                  end
                  if (cnt_eff == '0) begin
                     state_in = ced_pkg::ST_ACK;
                  end else begin
                     state_in = ced_pkg::ST_MARK;
                     idx_in   = IW'(cnt_eff - CW'(1));
                     more_in  = 1'b1;
                  end
               end else if ((phase_ff == ced_pkg::PH_PWR) &&
                            (mtype == ced_pkg::MT_PWR_OK)) begin
                  out_v_in   = 1'b1;
                  out_msg_in = ced_pkg::PWR_ACK | {32'b0, req_msg_word[31:0]};
                  phase_in   = ced_pkg::PH_IDLE;
               end else begin
                  out_v_in    = 1'b1;
                  out_kind_in = ced_pkg::KIND_DROP;
                  out_msg_in  = req_msg_word;
               end
            end
         end
         ced_pkg::ST_MARK: begin
            // issue reads from the top entry down; the first hit of a number owns it
            if (more_ff) begin
               mrdv_in    = 1'b1;
               mrd_idx_in = idx_ff;
               if (idx_ff == '0) begin
                  more_in = 1'b0;
               end else begin
                  idx_in = idx_ff - IW'(1);
               end
            end
            if (mrdv_ff && blk_match) begin
               seen_in[ep[4:0]] = 1'b1;
               if (bitmap_ff[ep[4:0]] && !seen_ff[ep[4:0]]) begin
                  flags_in[mrd_idx_ff] = 1'b1;
               end
            end
            if (!more_ff && !mrdv_ff) begin
               state_in = ced_pkg::ST_ACK;
            end
         end
         ced_pkg::ST_ACK: begin
            out_v_in    = 1'b1;
            out_kind_in = ced_pkg::KIND_SEND;
            out_msg_in  = ced_pkg::MAP_ACK
                          | {12'b0, lastblk_ff, 16'b0, block_ff, 32'b0}
                          | {63'b0, (block_ff == 3'd0)};
            if (lastblk_ff && (active_flags != '0)) begin
               out_last_in = 1'b0;
               pending_in  = active_flags;
               state_in    = ced_pkg::ST_START;
            end else begin
               state_in = ced_pkg::ST_IDLE;
            end
         end
         ced_pkg::ST_START: begin
            if (pending_ff != '0) begin
               srdv_in    = 1'b1;
               slast_in   = (pend_next == '0);
               pending_in = pend_next;
            end else if (!srdv_ff) begin
               state_in = ced_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ced_pkg::ST_IDLE;
         end
      endcase

      // register writes must arrive only while idle; the block itself does not enforce it
      if (csr_we) begin
         case (csr_index)
            ced_pkg::CSR_DISC_EN: begin
               disc_en_in = csr_wdata[0];
               phase_in   = csr_wdata[0] ? ced_pkg::PH_HELLO : ced_pkg::PH_IDLE;
               flags_in   = '0;
            end
            default: begin
               entry_count_in = csr_wdata;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ced_pkg::ST_IDLE;
         phase_ff       <= ced_pkg::PH_HELLO;
         disc_en_ff     <= 1'b1;
         entry_count_ff <= '0;
         flags_ff       <= '0;
         more_ff        <= 1'b0;
         mrdv_ff        <= 1'b0;
         pending_ff     <= '0;
         srdv_ff        <= 1'b0;
         out_v_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         disc_en_ff     <= disc_en_in;
         entry_count_ff <= entry_count_in;
         flags_ff       <= flags_in;
         more_ff        <= more_in;
         mrdv_ff        <= mrdv_in;
         pending_ff     <= pending_in;
         srdv_ff        <= srdv_in;
         out_v_ff       <= out_v_in;
      end
      idx_ff      <= idx_in;
      mrd_idx_ff  <= mrd_idx_in;
      seen_ff     <= seen_in;
      bitmap_ff   <= bitmap_in;
      block_ff    <= block_in;
      lastblk_ff  <= lastblk_in;
      slast_ff    <= slast_in;
      out_kind_ff <= out_kind_in;
      out_msg_ff  <= out_msg_in;
      out_last_ff <= out_last_in;
   end

   // result word: start words come straight from the table read register
   assign rsp_strobe      = out_v_ff | srdv_ff;
   assign rsp_result_kind = srdv_ff ? ced_pkg::KIND_SEND : out_kind_ff;
   assign rsp_out_msg     = srdv_ff ? (ced_pkg::START_MSG | {24'b0, rd_data_ff, 32'b0})
                                    : out_msg_ff;
   assign rsp_last        = srdv_ff ? slast_ff : out_last_ff;
   assign rsp_phase_now   = phase_ff;
   assign rsp_send_permit = (phase_ff == ced_pkg::PH_IDLE) ? ced_pkg::PERMIT_ALL :
                            (phase_ff == ced_pkg::PH_PWR)  ? ced_pkg::PERMIT_LOW :
                                                             ced_pkg::PERMIT_MGMT;

   // the discovery-enable copy has no reader besides this check
   `ASSERT_IMPLIES(a_en_phase, clock, reset,
      (!busy && !disc_en_ff && (phase_ff == ced_pkg::PH_HELLO)), 1'b0)
   `ASSERT_IMPLIES(a_one_source, clock, reset, out_v_ff, !srdv_ff)
   `ASSERT_IMPLIES(a_start_phase, clock, reset, srdv_ff, (phase_ff == ced_pkg::PH_PWR))
   `ASSERT_IMPLIES(a_pend_in_range, clock, reset, 1'b1, ((pending_ff & ~cnt_mask) == '0))
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_strobe)

endmodule
`default_nettype wire
